[rtl/core/mld_pkg.sv]
// ----------------------------------------------------------------------------
// mld_pkg
// Shared types and constants of the mipmap level downsampler.
// ----------------------------------------------------------------------------
package mld_pkg;

	localparam int CH_W   = 16;   // channel width, unsigned Q0.16
	localparam int CFG_W  = 13;   // size register width
	localparam int QW     = 16;   // quotient bits out of the divider
	localparam int PADDR_W = 3;

	// register index as decoded from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
		logic            end_of_level;
	} result_t;

	// vertical work for one horizontally finished column
	typedef struct packed {
		logic do_close;  // output row completes: sum goes to the divider
		logic rd_acc;    // close/add include the stored row accumulator
		logic rd_odd;    // accumulator read (and add write-back) is the odd-row one
		logic do_open;   // start a new row sum
		logic wr_odd;    // the opened row sum goes to the odd-row store
		logic do_add;    // middle row of an odd axis: accumulate in place
		logic eol;       // last output pixel of the level
	} vop_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ACC,
		B_DIV,
		B_OUT
	} b_state_t;

endpackage

[rtl/core/mld_ram.sv]
// ----------------------------------------------------------------------------
// mld_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mld_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/mld_fifo.sv]
// ----------------------------------------------------------------------------
// mld_fifo
// Small register FIFO that decouples the front and back parts.
// ----------------------------------------------------------------------------
module mld_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/mld_front.sv]
// ----------------------------------------------------------------------------
// mld_front
// Takes pixels, runs the horizontal filter and classifies the vertical work
// for each finished column sum.
// ----------------------------------------------------------------------------
module mld_front import mld_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int CHANNELS  = 4,
	parameter int SW        = $clog2(MAX_WIDTH + 1),
	parameter int PW        = $clog2(MAX_WIDTH),
	parameter int NW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
	parameter int HW        = SW + CH_W,
	parameter int DW        = 2 * SW
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [CFG_W-1:0]                 cfg_width,
	input  logic [CFG_W-1:0]                 cfg_height,
	input  logic                             restart,
	input  logic                             push,
	input  pixel_t                           pixel,
	input  logic                             rec_full,
	output logic                             rec_valid,
	output vop_t                             rec_vop,
	output logic [SW-1:0]                    rec_wa,
	output logic [SW-1:0]                    rec_wb,
	output logic [NW-1:0]                    rec_nx,
	output logic [CHANNELS-1:0][HW-1:0]      rec_hsum,
	output logic [DW-1:0]                    den
);

	logic [PW-1:0]               col_q, row_q;
	logic [CHANNELS-1:0][HW-1:0] partial_q;
	logic [DW-1:0]               den_q;

	logic [SW-1:0] wdt, hgt, ow, oh, dx, dy;
	logic          w_one, w_odd, h_one, h_odd;
	logic [PW-1:0] hc, hr, nx_full, mclose;
	logic          hz_close, hz_fresh, hz_open, hz_add;
	logic [SW-1:0] wc, wo, wa, wb;
	vop_t          vop;
	logic          accept, col_wrap, row_wrap;
	logic [3:0][CH_W-1:0]        px_all;
	logic [CHANNELS-1:0][HW-1:0] mc, mo, hsum;

	// a size of 0 acts as 1, anything above MAX_WIDTH as MAX_WIDTH
	assign wdt = (cfg_width == '0) ? SW'(1) :
		((32'(cfg_width) > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(cfg_width));
	assign hgt = (cfg_height == '0) ? SW'(1) :
		((32'(cfg_height) > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(cfg_height));
	assign w_one = (wdt == SW'(1));
	assign h_one = (hgt == SW'(1));
	assign w_odd = wdt[0];
	assign h_odd = hgt[0];
	assign ow    = w_one ? SW'(1) : (wdt >> 1);
	assign oh    = h_one ? SW'(1) : (hgt >> 1);
	assign dx    = w_one ? SW'(1) : (w_odd ? wdt : SW'(2));
	assign dy    = h_one ? SW'(1) : (h_odd ? hgt : SW'(2));
	assign hc    = col_q >> 1;
	assign hr    = row_q >> 1;

	assign accept = push && !rec_full;
	assign px_all = {pixel.alpha, pixel.blue, pixel.green, pixel.red};

	// horizontal taps of this column
	always_comb begin
		hz_close = 1'b0;
		hz_fresh = 1'b0;
		hz_open  = 1'b0;
		hz_add   = 1'b0;
		wc       = '0;
		wo       = '0;
		nx_full  = '0;
		if (w_one) begin
			hz_close = 1'b1;
			hz_fresh = 1'b1;
			wc       = SW'(1);
		end else if (!w_odd) begin
			if (col_q[0]) begin
				hz_close = 1'b1;
				wc       = SW'(1);
				nx_full  = hc;
			end else begin
				hz_open = 1'b1;
				wo      = SW'(1);
			end
		end else if (col_q[0]) begin
			hz_add = 1'b1;
			wc     = ow;
		end else begin
			// odd axis, even column: closes the previous output, opens the next
			if (hc != '0) begin
				hz_close = 1'b1;
				wc       = SW'(hc);
				nx_full  = hc - 1'b1;
			end
			if (SW'(hc) < ow) begin
				hz_open = 1'b1;
				wo      = ow - SW'(hc);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			mc[c]   = {{CH_W{1'b0}}, wc} * {{SW{1'b0}}, px_all[c]};
			mo[c]   = {{CH_W{1'b0}}, wo} * {{SW{1'b0}}, px_all[c]};
			hsum[c] = (hz_fresh ? '0 : partial_q[c]) + mc[c];
		end
	end

	// vertical classification of this row
	always_comb begin
		vop    = '0;
		wa     = '0;
		wb     = '0;
		mclose = '0;
		if (h_one) begin
			vop.do_close = 1'b1;
			wa           = SW'(1);
		end else if (!h_odd) begin
			if (row_q[0]) begin
				vop.do_close = 1'b1;
				vop.rd_acc   = 1'b1;
				vop.rd_odd   = hr[0];
				wa           = SW'(1);
				mclose       = hr;
			end else begin
				vop.do_open = 1'b1;
				vop.wr_odd  = hr[0];
				wb          = SW'(1);
			end
		end else if (row_q[0]) begin
			vop.do_add = 1'b1;
			vop.rd_acc = 1'b1;
			vop.rd_odd = hr[0];
			wa         = oh;
		end else begin
			if (hr != '0) begin
				vop.do_close = 1'b1;
				vop.rd_acc   = 1'b1;
				vop.rd_odd   = ~hr[0];
				wa           = SW'(hr);
				mclose       = hr - 1'b1;
			end
			if (SW'(hr) < oh) begin
				vop.do_open = 1'b1;
				vop.wr_odd  = hr[0];
				wb          = oh - SW'(hr);
			end
		end
		vop.eol = vop.do_close && (SW'(nx_full) == ow - SW'(1)) &&
			(SW'(mclose) == oh - SW'(1));
	end

	assign col_wrap = (SW'(col_q) + SW'(1)) >= wdt;
	assign row_wrap = (SW'(row_q) + SW'(1)) >= hgt;

	assign rec_valid = accept && hz_close;
	assign rec_vop   = vop;
	assign rec_wa    = wa;
	assign rec_wb    = wb;
	assign rec_nx    = NW'(nx_full);
	assign rec_hsum  = hsum;
	assign den       = den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			partial_q <= '0;
			den_q     <= DW'(1);
		end else begin
			den_q <= {{SW{1'b0}}, dx} * {{SW{1'b0}}, dy};
			if (restart) begin
				col_q     <= '0;
				row_q     <= '0;
				partial_q <= '0;
			end else if (accept) begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (hz_open) begin
						partial_q[c] <= mo[c];
					end else if (hz_add) begin
						partial_q[c] <= partial_q[c] + mc[c];
					end
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/mld_back.sv]
// ----------------------------------------------------------------------------
// mld_back
// Vertical filter: row accumulators in RAM, weight multiply, rounding
// division by the filter denominator and the result register.
// ----------------------------------------------------------------------------
module mld_back import mld_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int CHANNELS  = 4,
	parameter int SW        = $clog2(MAX_WIDTH + 1),
	parameter int NW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
	parameter int HW        = SW + CH_W,
	parameter int DW        = 2 * SW,
	parameter int AW        = SW + HW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  vop_t                        q_vop,
	input  logic [SW-1:0]               q_wa,
	input  logic [SW-1:0]               q_wb,
	input  logic [NW-1:0]               q_nx,
	input  logic [CHANNELS-1:0][HW-1:0] q_hsum,
	input  logic [DW-1:0]               den,
	input  logic                        pop,
	output logic                        empty,
	output result_t                     result
);

	localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
	localparam int RW    = AW + 1;
	localparam int CW    = $clog2(QW);

	b_state_t state_q, state_d;

	vop_t                        vop_q;
	logic [SW-1:0]               wa_q, wb_q;
	logic [NW-1:0]               nx_q;
	logic [CHANNELS-1:0][HW-1:0] hsum_q;
	logic [CHANNELS-1:0][AW-1:0] va_q, vb_q;
	logic [CHANNELS-1:0][RW-1:0] rem_q;
	logic [CHANNELS-1:0][QW-1:0] quo_q;
	logic [CHANNELS-1:0]         sat_q;
	logic [AW-1:0]               dsh_q;
	logic [CW-1:0]               cnt_q;
	logic                        out_valid_q;
	result_t                     result_q;

	logic [CHANNELS-1:0][AW-1:0] even_rd, odd_rd, acc, sum, wr_data;
	logic [CHANNELS-1:0][RW-1:0] rem_init;
	logic                        take, mul_en, load_div, step_en, emit;
	logic                        we_even, we_odd;
	logic [3:0][CH_W-1:0]        och;
	result_t                     res_d;

	mld_ram #(.WIDTH(CHANNELS * AW), .DEPTH(DEPTH)) u_acc_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (nx_q),
		.wdata (wr_data),
		.re    (take),
		.raddr (q_nx),
		.rdata (even_rd)
	);

	mld_ram #(.WIDTH(CHANNELS * AW), .DEPTH(DEPTH)) u_acc_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (nx_q),
		.wdata (wr_data),
		.re    (take),
		.raddr (q_nx),
		.rdata (odd_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_d = B_MUL;
			B_MUL:  state_d = B_ACC;
			B_ACC:  state_d = vop_q.do_close ? B_DIV : B_IDLE;
			B_DIV:  if (cnt_q == CW'(QW - 1)) state_d = B_OUT;
			B_OUT:  if (!out_valid_q || pop) state_d = B_IDLE;
		endcase
	end

	always_comb begin
		take     = 1'b0;
		mul_en   = 1'b0;
		load_div = 1'b0;
		step_en  = 1'b0;
		emit     = 1'b0;
		we_even  = 1'b0;
		we_odd   = 1'b0;
		unique case (state_q)
			B_IDLE: take = !q_empty;
			B_MUL:  mul_en = 1'b1;
			B_ACC: begin
				load_div = vop_q.do_close;
				we_even  = (vop_q.do_open && !vop_q.wr_odd) || (vop_q.do_add && !vop_q.rd_odd);
				we_odd   = (vop_q.do_open && vop_q.wr_odd) || (vop_q.do_add && vop_q.rd_odd);
			end
			B_DIV:  step_en = 1'b1;
			B_OUT:  emit = !out_valid_q || pop;
		endcase
	end

	assign q_pop = take;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			acc[c]      = vop_q.rd_odd ? odd_rd[c] : even_rd[c];
			sum[c]      = (vop_q.rd_acc ? acc[c] : '0) + va_q[c];
			wr_data[c]  = vop_q.do_open ? vb_q[c] : sum[c];
			// round half up: add half the denominator before dividing
			rem_init[c] = RW'(sum[c]) + RW'(den >> 1);
		end
	end

	always_comb begin
		och = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			och[c] = quo_q[c] | {QW{sat_q[c]}};
		end
		res_d.out_red      = och[0];
		res_d.out_green    = och[1];
		res_d.out_blue     = och[2];
		res_d.out_alpha    = och[3];
		res_d.end_of_level = vop_q.eol;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			vop_q  <= q_vop;
			wa_q   <= q_wa;
			wb_q   <= q_wb;
			nx_q   <= q_nx;
			hsum_q <= q_hsum;
		end
		if (mul_en) begin
			for (int c = 0; c < CHANNELS; c++) begin
				va_q[c] <= {{HW{1'b0}}, wa_q} * {{SW{1'b0}}, hsum_q[c]};
				vb_q[c] <= {{HW{1'b0}}, wb_q} * {{SW{1'b0}}, hsum_q[c]};
			end
		end
		// restoring divider, one quotient bit per cycle on every lane
		if (load_div) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rem_q[c] <= rem_init[c];
				quo_q[c] <= '0;
				sat_q[c] <= rem_init[c] >= RW'({den, {QW{1'b0}}});
			end
			dsh_q <= AW'({den, {(QW - 1){1'b0}}});
		end else if (step_en) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (rem_q[c] >= RW'(dsh_q)) begin
					rem_q[c] <= rem_q[c] - RW'(dsh_q);
					quo_q[c] <= {quo_q[c][QW-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][QW-2:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_div) begin
				cnt_q <= '0;
			end else if (step_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

endmodule

[rtl/core/mipmap_level_downsampler.sv]
// ----------------------------------------------------------------------------
// mipmap_level_downsampler
// Streams one RGBA level in raster order and produces the next mipmap level.
// ----------------------------------------------------------------------------
// Pixels enter at one per cycle while the internal queue has room; the front
// filters horizontally in the cycle a pixel is taken. Every output pixel then
// passes through the vertical unit (queue pop, weight multiply, accumulator
// update, 16-step rounding divide, result load); input rows that only open or
// extend row sums stop after the accumulator update. The vertical unit takes
// one queued column at a time and the divide is its longest step. Row
// accumulators live in two RAMs of MAX_WIDTH/2 entries that need no clearing.
// Writing either size register restarts the level at the first pixel; write
// it only while idle.
module mipmap_level_downsampler import mld_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int CHANNELS  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  pixel_t             pixel,
	output logic               empty,
	input  logic               pop,
	output result_t            result
);

	localparam int SW   = $clog2(MAX_WIDTH + 1);
	localparam int PW   = $clog2(MAX_WIDTH);
	localparam int NW   = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
	localparam int HW   = SW + CH_W;
	localparam int DW   = 2 * SW;
	localparam int AW   = SW + HW;
	localparam int RECW = $bits(vop_t) + 2 * SW + NW + CHANNELS * HW;

	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr;

	logic                        rec_valid, q_full, q_empty, q_pop;
	vop_t                        rec_vop, hd_vop;
	logic [SW-1:0]               rec_wa, rec_wb, hd_wa, hd_wb;
	logic [NW-1:0]               rec_nx, hd_nx;
	logic [CHANNELS-1:0][HW-1:0] rec_hsum, hd_hsum;
	logic [DW-1:0]               den;
	logic [RECW-1:0]             q_wdata, q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[CFG_W-1:0];
			end else begin
				height_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	mld_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS),
		.SW        (SW),
		.PW        (PW),
		.NW        (NW),
		.HW        (HW),
		.DW        (DW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.restart    (cfg_wr),
		.push       (push),
		.pixel      (pixel),
		.rec_full   (q_full),
		.rec_valid  (rec_valid),
		.rec_vop    (rec_vop),
		.rec_wa     (rec_wa),
		.rec_wb     (rec_wb),
		.rec_nx     (rec_nx),
		.rec_hsum   (rec_hsum),
		.den        (den)
	);

	assign full    = q_full;
	assign q_wdata = {rec_vop, rec_wa, rec_wb, rec_nx, rec_hsum};
	assign {hd_vop, hd_wa, hd_wb, hd_nx, hd_hsum} = q_rdata;

	mld_fifo #(.WIDTH(RECW), .DEPTH(2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_valid),
		.wdata  (q_wdata),
		.rd_en  (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	mld_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS),
		.SW        (SW),
		.NW        (NW),
		.HW        (HW),
		.DW        (DW),
		.AW        (AW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_vop   (hd_vop),
		.q_wa    (hd_wa),
		.q_wb    (hd_wb),
		.q_nx    (hd_nx),
		.q_hsum  (hd_hsum),
		.den     (den),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

[rtl/core/mld_checker.sv]
// ----------------------------------------------------------------------------
// mld_checker
// Port-level checks of the mipmap level downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module mld_checker import mld_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               empty,
	input logic               pop,
	input result_t            result
);

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed or vanished before its transfer");

	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_WIDTH)
		|=> ((psel && !pwrite && paddr[2] == REG_WIDTH) ->
			(prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))))
		else $error("width register read back differs from last write");

	a_height_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_HEIGHT)
		|=> ((psel && !pwrite && paddr[2] == REG_HEIGHT) ->
			(prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))))
		else $error("height register read back differs from last write");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> (prdata[31:CFG_W] == '0))
		else $error("unused register bits read nonzero");

endmodule

bind mipmap_level_downsampler mld_checker u_mld_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.empty   (empty),
	.pop     (pop),
	.result  (result)
);
